@@ rtl/smtp_dot_stuffer_unit_defines.svh @@
// Assertion macros for the SMTP dot stuffer unit.
// Used by the top level; needs nothing else.
`ifndef SMTP_DOT_STUFFER_UNIT_DEFINES_SVH
`define SMTP_DOT_STUFFER_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante, outside reset
`define SDS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante, outside reset
`define SDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sds_pkg.sv @@
// Shared types, character constants and expansion tables of the dot stuffer.
// No dependencies; used by every module of the unit.
package sds_pkg;

    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;

    // Output pattern of one accepted item
    typedef enum logic [2:0] {
        K_BYTE = 3'd0,  // the byte itself
        K_DOT2 = 3'd1,  // dot doubled at line start
        K_CRB  = 3'd2,  // released CR, then the byte
        K_CR   = 3'd3,  // released CR only
        K_CRLF = 3'd4,  // line ending
        K_END  = 3'd5,  // terminator only
        K_ENDL = 3'd6   // line ending, then terminator
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // Index of the last byte a command expands into
    function automatic logic [2:0] kind_last(input t_kind kind);
        logic [2:0] res;
        case (kind)
            K_BYTE:  res = 3'd0;
            K_DOT2:  res = 3'd1;
            K_CRB:   res = 3'd1;
            K_CR:    res = 3'd0;
            K_CRLF:  res = 3'd1;
            K_END:   res = 3'd2;
            K_ENDL:  res = 3'd4;
            default: res = 3'd0;
        endcase
        return res;
    endfunction

    // Byte at position idx of a command's expansion
    function automatic logic [7:0] kind_byte(input t_kind kind, input logic [2:0] idx,
                                             input logic [7:0] data);
        logic [7:0] res;
        res = data;
        case (kind)
            K_BYTE:  res = data;
            K_DOT2:  res = (idx == 3'd0) ? CH_DOT : data;
            K_CRB:   res = (idx == 3'd0) ? CH_CR : data;
            K_CR:    res = CH_CR;
            K_CRLF:  res = (idx == 3'd0) ? CH_CR : CH_LF;
            K_END: begin
                case (idx)
                    3'd0:    res = CH_DOT;
                    3'd1:    res = CH_CR;
                    default: res = CH_LF;
                endcase
            end
            K_ENDL: begin
                case (idx)
                    3'd0:    res = CH_CR;
                    3'd1:    res = CH_LF;
                    3'd2:    res = CH_DOT;
                    3'd3:    res = CH_CR;
                    default: res = CH_LF;
                endcase
            end
            default: res = data;
        endcase
        return res;
    endfunction

endpackage

@@ rtl/sds_front.sv @@
// Front end: accepts input beats, tracks line state, emits expansion commands.
// Depends on sds_pkg.
module sds_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_op,
    input  logic [7:0]    i_data,
    input  logic          i_room,
    output logic          o_ready,
    output logic          o_push,
    output sds_pkg::t_cmd o_cmd
);
    import sds_pkg::*;

    logic r_at_start, n_at_start;
    logic r_held_cr, n_held_cr;
    logic accept;
    logic has_out;
    t_kind kind;

    assign o_ready = i_room;
    assign accept  = i_valid && i_room;

    // Classify the beat and compute the next line state
    always_comb begin
        kind       = K_BYTE;
        has_out    = 1'b1;
        n_at_start = r_at_start;
        n_held_cr  = r_held_cr;
        if (i_op) begin
            kind       = (r_held_cr || !r_at_start) ? K_ENDL : K_END;
            n_at_start = 1'b1;
            n_held_cr  = 1'b0;
        end else if (i_data == CH_LF) begin
            kind       = K_CRLF;
            n_at_start = 1'b1;
            n_held_cr  = 1'b0;
        end else if (i_data == CH_CR) begin
            kind       = K_CR;
            has_out    = r_held_cr;
            n_held_cr  = 1'b1;
            n_at_start = 1'b0;
        end else begin
            if (r_held_cr) begin
                kind = K_CRB;
            end else if (r_at_start && i_data == CH_DOT) begin
                kind = K_DOT2;
            end else begin
                kind = K_BYTE;
            end
            n_held_cr  = 1'b0;
            n_at_start = 1'b0;
        end
    end

    assign o_push     = accept && has_out;
    assign o_cmd.kind = kind;
    assign o_cmd.data = i_data;

    // Advance line state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
            r_held_cr  <= 1'b0;
        end else if (accept) begin
            r_at_start <= n_at_start;
            r_held_cr  <= n_held_cr;
        end
    end

endmodule

@@ rtl/sds_fifo.sv @@
// Short command queue between front and back end.
// Depends on sds_pkg.
module sds_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sds_pkg::t_cmd       i_cmd,
    input  logic                i_pop,
    output sds_pkg::t_cmd       o_cmd,
    output sds_pkg::t_fifo_stat o_stat
);
    import sds_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic do_push;
    logic do_pop;

    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.empty = (r_count == '0);
    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_MAX) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_MAX) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/sds_back.sv @@
// Back end: expands queued commands into output bytes, one beat per cycle while commands are queued and
// the receiver is ready. Depends on sds_pkg.
module sds_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_avail,
    input  sds_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_data,
    output logic          o_last,
    output logic          o_done
);
    import sds_pkg::*;

    logic [2:0] r_idx;
    logic       r_valid;
    logic [7:0] r_data;
    logic       r_last;
    logic       r_done;
    logic       load;
    logic       at_last;

    assign load    = !r_valid || i_ready;
    assign at_last = (r_idx == kind_last(i_cmd.kind));
    assign o_pop   = load && i_avail && at_last;

    // Walk the head command; hold the output register while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_avail;
            if (i_avail) begin
                r_idx <= at_last ? 3'd0 : r_idx + 3'd1;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load && i_avail) begin
            r_data <= kind_byte(i_cmd.kind, r_idx, i_cmd.data);
            r_last <= at_last;
            r_done <= at_last && (i_cmd.kind == K_END || i_cmd.kind == K_ENDL);
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;
    assign o_done  = r_done;

endmodule

@@ rtl/smtp_dot_stuffer_unit.sv @@
// Top level of the SMTP dot stuffer; depends on sds_pkg, sds_front, sds_fifo and sds_back.
// The first byte of an accepted beat is written to the command queue, then registered in the back
// end's output register, where the receiver can take it.
// Throughput: one input beat per cycle; one output beat per cycle while the receiver is ready. Each
// byte of an expansion (up to five for an end of message) takes its own output beat; the input stalls
// only while the FIFO_DEPTH-entry queue is full. Reset: line start, no CR held, queue empty.
module smtp_dot_stuffer_unit #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic       i_s_tuser,   // [0] op (1 = end of message)
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast,   // run_last
    output logic       o_m_tuser    // [0] message_done
);
    import sds_pkg::*;

`include "smtp_dot_stuffer_unit_defines.svh"

    t_cmd       push_cmd;
    t_cmd       head_cmd;
    t_fifo_stat fifo_stat;
    logic       push;
    logic       pop;

    // Classify input beats
    sds_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_op    (i_s_tuser),
        .i_data  (i_s_tdata),
        .i_room  (!fifo_stat.full),
        .o_ready (o_s_tready),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    // Queue commands
    sds_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (fifo_stat)
    );

    // Expand commands into output beats
    sds_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (!fifo_stat.empty),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata),
        .o_last  (o_m_tlast),
        .o_done  (o_m_tuser)
    );

    `SDS_ASSERT_SAME(a_done_is_last_lf, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, o_m_tlast && (o_m_tdata == CH_LF), "message done on a beat other than the final LF")
    `SDS_ASSERT_SAME(a_queue_sane, i_clk, i_rst_n, 1'b1, !(fifo_stat.full && fifo_stat.empty), "queue full and empty at once")
    `SDS_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, push && !pop, !fifo_stat.empty, "queue empty after a push")

endmodule

@@ tb/tb_smtp_dot_stuffer_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the SMTP dot stuffer unit: a directed table, then random messages.
// Depends on sds_pkg and smtp_dot_stuffer_unit; needs no files or arguments.
module tb_smtp_dot_stuffer_unit;
    import sds_pkg::*;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_EOM  = 1'b1;
    localparam int   DIR_N = 25;
    localparam int   RAND_ITEMS = 400;
    localparam int   HOLD_CYCLES = 60;
    localparam int   CYCLE_LIMIT = 200000;

    // One directed row; seq holds typed bytes, first byte in the lowest bits
    typedef struct packed {
        logic        op;
        logic [7:0]  data;
        logic        typed;
        logic [2:0]  cnt;
        logic [39:0] seq;
    } t_dir_row;

    // One expected output beat
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       done;
    } t_stuffed;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata = 8'h00;  // [7:0] data_byte
    logic       i_s_tuser = 1'b0;   // [0] op (1 = end of message)
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;          // [7:0] out_byte
    logic       o_m_tlast;
    logic       o_m_tuser;          // [0] message_done

    t_dir_row dir_tab [DIR_N] = '{
        '{OP_EOM,  8'h00,  1'b1, 3'd3, {16'h0, CH_LF, CH_CR, CH_DOT}},
        '{OP_BYTE, CH_DOT, 1'b1, 3'd2, {24'h0, CH_DOT, CH_DOT}},
        '{OP_BYTE, 8'h00,  1'b1, 3'd1, {32'h0, 8'h00}},
        '{OP_BYTE, 8'hFF,  1'b1, 3'd1, {32'h0, 8'hFF}},
        '{OP_BYTE, CH_LF,  1'b1, 3'd2, {24'h0, CH_LF, CH_CR}},
        '{OP_BYTE, CH_CR,  1'b1, 3'd0, 40'h0},
        '{OP_BYTE, CH_DOT, 1'b0, 3'd0, 40'h0},
        '{OP_BYTE, CH_CR,  1'b0, 3'd0, 40'h0},
        '{OP_BYTE, CH_CR,  1'b0, 3'd0, 40'h0},
        '{OP_BYTE, CH_LF,  1'b0, 3'd0, 40'h0},
        '{OP_EOM,  8'hFF,  1'b1, 3'd3, {16'h0, CH_LF, CH_CR, CH_DOT}},
        '{OP_BYTE, 8'h41,  1'b0, 3'd0, 40'h0},
        '{OP_EOM,  8'h5A,  1'b0, 3'd0, 40'h0},
        '{OP_BYTE, CH_CR,  1'b0, 3'd0, 40'h0},
        '{OP_EOM,  8'h00,  1'b0, 3'd0, 40'h0},
        '{OP_BYTE, CH_CR,  1'b0, 3'd0, 40'h0},
        '{OP_BYTE, CH_LF,  1'b0, 3'd0, 40'h0},
        '{OP_BYTE, CH_DOT, 1'b0, 3'd0, 40'h0},
        '{OP_BYTE, 8'h55,  1'b0, 3'd0, 40'h0},
        '{OP_BYTE, 8'hAA,  1'b0, 3'd0, 40'h0},
        '{OP_BYTE, CH_CR,  1'b0, 3'd0, 40'h0},
        '{OP_BYTE, 8'h78,  1'b0, 3'd0, 40'h0},
        '{OP_BYTE, CH_DOT, 1'b0, 3'd0, 40'h0},
        '{OP_BYTE, CH_LF,  1'b0, 3'd0, 40'h0},
        '{OP_EOM,  8'hAB,  1'b0, 3'd0, 40'h0}
    };

    t_stuffed stuffed_q [$];
    logic     pred_line_start = 1'b1;
    logic     pred_cr_held = 1'b0;
    int       n_err = 0;
    int       n_acc = 0;
    int       n_out = 0;
    int       n_msgs = 0;
    int       n_sent = 0;
    int       cyc = 0;
    int       tx_idle_pct = 0;
    int       rx_idle_pct = 0;
    bit       rx_hold_req = 1'b0;

    smtp_dot_stuffer_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    // Free-running clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Predict the stuffed bytes of one input beat and advance the line state
    function automatic void stuff_beat(input logic op, input logic [7:0] b,
                                       output logic [39:0] seq, output int cnt);
        seq = '0;
        cnt = 0;
        if (op == OP_EOM) begin
            // close an open line, then the terminator
            if (pred_cr_held || !pred_line_start) begin
                seq[8*cnt +: 8] = CH_CR; cnt++;
                seq[8*cnt +: 8] = CH_LF; cnt++;
            end
            seq[8*cnt +: 8] = CH_DOT; cnt++;
            seq[8*cnt +: 8] = CH_CR;  cnt++;
            seq[8*cnt +: 8] = CH_LF;  cnt++;
            pred_line_start = 1'b1;
            pred_cr_held = 1'b0;
        end else if (b == CH_LF) begin
            // a held CR is absorbed into the line ending
            seq[8*cnt +: 8] = CH_CR; cnt++;
            seq[8*cnt +: 8] = CH_LF; cnt++;
            pred_line_start = 1'b1;
            pred_cr_held = 1'b0;
        end else if (b == CH_CR) begin
            if (pred_cr_held) begin
                seq[8*cnt +: 8] = CH_CR; cnt++;
            end
            pred_cr_held = 1'b1;
            pred_line_start = 1'b0;
        end else begin
            if (pred_cr_held) begin
                seq[8*cnt +: 8] = CH_CR; cnt++;
                pred_cr_held = 1'b0;
            end else if (pred_line_start && b == CH_DOT) begin
                seq[8*cnt +: 8] = CH_DOT; cnt++;
            end
            seq[8*cnt +: 8] = b; cnt++;
            pred_line_start = 1'b0;
        end
    endfunction

    // Offer one beat with random leading gaps; return at the falling edge after accept
    task automatic send_beat(input logic op, input logic [7:0] data);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= data;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
        n_sent++;
    endtask

    // Well-formed message: a few lines of random content with mixed endings
    task automatic send_message();
        int         n_lines;
        int         len;
        int         r;
        logic [7:0] b;
        n_lines = $urandom_range(0, 4);
        for (int k = 0; k < n_lines; k++) begin
            len = $urandom_range(0, 6);
            for (int j = 0; j < len; j++) begin
                r = $urandom_range(0, 19);
                if (r < 4)       b = CH_DOT;
                else if (r == 4) b = CH_CR;
                else if (r == 5) b = 8'($urandom_range(0, 255));
                else             b = 8'($urandom_range(8'h20, 8'h7E));
                send_beat(OP_BYTE, b);
            end
            case ($urandom_range(0, 4))
                0: send_beat(OP_BYTE, CH_LF);
                1: begin
                    send_beat(OP_BYTE, CH_CR);
                    send_beat(OP_BYTE, CH_LF);
                end
                2: begin
                    send_beat(OP_BYTE, CH_CR);
                    send_beat(OP_BYTE, CH_CR);
                    send_beat(OP_BYTE, CH_LF);
                end
                3: send_beat(OP_BYTE, CH_CR);
                default: ;
            endcase
        end
        send_beat(OP_EOM, 8'($urandom_range(0, 255)));
    endtask

    // Noise: raw random bytes, now and then an end of message
    task automatic send_noise();
        int len;
        len = $urandom_range(1, 8);
        for (int j = 0; j < len; j++) begin
            send_beat(($urandom_range(0, 7) == 0) ? OP_EOM : OP_BYTE,
                      8'($urandom_range(0, 255)));
        end
    endtask

    // Receiver: random stalls, plus one long hold on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_m_tready <= 1'b0;
                hold_left--;
            end else if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Predict on input accept, compare on output accept
    always @(posedge i_clk) begin
        logic [39:0] seq;
        int          cnt;
        t_stuffed    want;
        t_stuffed    exp_beat;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                stuff_beat(i_s_tuser, i_s_tdata, seq, cnt);
                if (n_acc < DIR_N && dir_tab[n_acc].typed) begin
                    seq = dir_tab[n_acc].seq;
                    cnt = int'(dir_tab[n_acc].cnt);
                end
                for (int k = 0; k < cnt; k++) begin
                    exp_beat.data = seq[8*k +: 8];
                    exp_beat.last = (k == cnt - 1);
                    exp_beat.done = (i_s_tuser == OP_EOM) && (k == cnt - 1);
                    stuffed_q.insert(stuffed_q.size(), exp_beat);
                end
                n_acc++;
            end
            if (o_m_tvalid && i_m_tready) begin
                n_out++;
                if (o_m_tuser) n_msgs++;
                if (stuffed_q.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, got data=%02h last=%b done=%b",
                             $time, o_m_tdata, o_m_tlast, o_m_tuser);
                    n_err++;
                end else begin
                    want = stuffed_q.pop_front();
                    if (want.data !== o_m_tdata || want.last !== o_m_tlast
                            || want.done !== o_m_tuser) begin
                        $display("%0t: mismatch expected data=%02h last=%b done=%b,",
                                 $time, want.data, want.last, want.done);
                        $display("%0t:          got data=%02h last=%b done=%b",
                                 $time, o_m_tdata, o_m_tlast, o_m_tuser);
                        n_err++;
                    end
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cyc < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cyc++;
        end
        $display("timeout after %0d cycles, %0d bytes outstanding", cyc, stuffed_q.size());
        $display("tb: failure");
        $finish;
    end

    // Stimulus
    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        tx_idle_pct = 15;
        rx_idle_pct = 46;
        for (int i = 0; i < DIR_N; i++) begin
            send_beat(dir_tab[i].op, dir_tab[i].data);
        end

        // random messages under three idle mixes
        for (int p = 0; p < 3; p++) begin
            tx_idle_pct = (p == 0) ? 15 : (p == 1) ? 46 : 0;
            rx_idle_pct = (p == 0) ? 46 : (p == 1) ? 15 : 0;
            if (p == 2) rx_hold_req = 1'b1;
            while (n_sent < DIR_N + RAND_ITEMS * (p + 1) / 3) begin
                if ($urandom_range(0, 9) == 0) send_noise();
                else                           send_message();
            end
        end
        i_s_tvalid <= 1'b0;

        // drain, then let the pipeline settle
        while (stuffed_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("run: %0d beats in (%0d directed), %0d bytes out, %0d messages closed",
                 n_acc, DIR_N, n_out, n_msgs);
        $display("run: idle mixes 15/46, 46/15 and none, with one %0d-cycle output hold",
                 HOLD_CYCLES);
        if (n_err == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", n_err);
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/sds_pkg.sv
rtl/sds_front.sv
rtl/sds_fifo.sv
rtl/sds_back.sv
rtl/smtp_dot_stuffer_unit.sv
tb/tb_smtp_dot_stuffer_unit.sv
